@@ rtl/ppurs_pkg.sv @@
package ppurs_pkg;

    localparam int OAM_BYTES_DEF = 256;

    typedef enum logic [3:0] {
        FN_READ      = 4'd0,
        FN_WRITE     = 4'd1,
        FN_PEEK      = 4'd2,
        FN_INC_X     = 4'd3,
        FN_INC_Y     = 4'd4,
        FN_XFER_X    = 4'd5,
        FN_XFER_Y    = 4'd6,
        FN_VBL_START = 4'd7,
        FN_VBL_END   = 4'd8
    } func_t;

    typedef logic [2:0] reg_sel_t;

    localparam reg_sel_t REG_CTRL     = 3'd0;
    localparam reg_sel_t REG_MASK     = 3'd1;
    localparam reg_sel_t REG_STATUS   = 3'd2;
    localparam reg_sel_t REG_OAM_ADDR = 3'd3;
    localparam reg_sel_t REG_OAM_DATA = 3'd4;
    localparam reg_sel_t REG_SCROLL   = 3'd5;
    localparam reg_sel_t REG_ADDR     = 3'd6;
    localparam reg_sel_t REG_DATA     = 3'd7;

    localparam logic [13:0] PALETTE_BASE  = 14'h3F00;
    localparam logic [4:0]  COARSE_Y_LAST = 5'd29;
    localparam logic [4:0]  COARSE_MAX    = 5'd31;
    localparam logic [2:0]  FINE_Y_MAX    = 3'd7;
    localparam logic [14:0] STEP_ACROSS   = 15'd1;
    localparam logic [14:0] STEP_DOWN     = 15'd32;

    function automatic logic [14:0] scroll_inc_x(input logic [14:0] v);
        logic [14:0] r;
        r = v;
        if (v[4:0] == COARSE_MAX)
        begin
            r[4:0] = 5'd0;
            r[10]  = ~v[10];
        end
        else
        begin
            r[4:0] = v[4:0] + 5'd1;
        end
        return r;
    endfunction

    function automatic logic [14:0] scroll_inc_y(input logic [14:0] v);
        logic [14:0] r;
        logic [4:0]  cy;
        r  = v;
        cy = v[9:5];
        if (v[14:12] != FINE_Y_MAX)
        begin
            r[14:12] = v[14:12] + 3'd1;
        end
        else
        begin
            r[14:12] = 3'd0;
            if (cy == COARSE_Y_LAST)
            begin
                cy    = 5'd0;
                r[11] = ~v[11];
            end
            else if (cy == COARSE_MAX)
            begin
                cy = 5'd0;
            end
            else
            begin
                cy = cy + 5'd1;
            end
            r[9:5] = cy;
        end
        return r;
    endfunction

endpackage

@@ rtl/ppu_register_and_scroll_port.sv @@
// A result is presented in the cycle after its request is accepted. One request
// per cycle while out_stall holds no result; a new request is taken while the
// output register drains; the only memory is the OAM array, read registered.
// Reset clears control, mask, status, OAM index, toggle, read buffer, both
// addresses and fine X. OAM contents are not cleared.
module ppu_register_and_scroll_port #(
    parameter int OAM_BYTES = ppurs_pkg::OAM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  func,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  write_data,
    input  logic [7:0]  vram_read_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        vram_write_enable,
    output logic [13:0] vram_write_address,
    output logic [7:0]  vram_write_data,
    output logic [14:0] vram_address_now,
    output logic [2:0]  fine_x_now,
    output logic        nmi_request
);
    import ppurs_pkg::*;

    localparam int OAM_AW = $clog2(OAM_BYTES);

    logic        in_accept;
    func_t       fn;

    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  oam_index_reg, oam_index_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic [14:0] v_reg, v_next;
    logic [14:0] t_reg, t_next;
    logic [2:0]  fine_x_reg, fine_x_next;

    logic [7:0]  rd;
    logic        oam_sel;
    logic        oam_wr;
    logic        we;
    logic [13:0] wa;
    logic [7:0]  wdat;
    logic        nmi;
    logic        render_on;
    logic [14:0] v_step;
    logic [7:0]  oam_q;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  rd_reg;
    logic        oam_sel_reg;
    logic        we_reg;
    logic [13:0] wa_reg;
    logic [7:0]  wdat_reg;
    logic [14:0] v_now_reg;
    logic [2:0]  fx_now_reg;
    logic        nmi_reg;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign fn        = func_t'(func);
    assign render_on = mask_reg[3] | mask_reg[4];
    assign v_step    = 15'(v_reg + (control_reg[2] ? STEP_DOWN : STEP_ACROSS));

    always_comb
    begin
        control_next   = control_reg;
        mask_next      = mask_reg;
        status_next    = status_reg;
        oam_index_next = oam_index_reg;
        toggle_next    = toggle_reg;
        rbuf_next      = rbuf_reg;
        v_next         = v_reg;
        t_next         = t_reg;
        fine_x_next    = fine_x_reg;
        rd             = 8'd0;
        oam_sel        = 1'b0;
        oam_wr         = 1'b0;
        we             = 1'b0;
        wa             = 14'd0;
        wdat           = 8'd0;
        nmi            = 1'b0;
        unique case (fn)
            FN_READ:
            begin
                unique case (reg_select)
                    REG_DATA:
                    begin
                        rd        = (v_reg[13:0] >= PALETTE_BASE) ? vram_read_data : rbuf_reg;
                        rbuf_next = vram_read_data;
                        v_next    = v_step;
                    end
                    REG_STATUS:
                    begin
                        rd             = {status_reg[7:5], rbuf_reg[4:0]};
                        status_next[7] = 1'b0;
                        toggle_next    = 1'b0;
                    end
                    REG_OAM_DATA:
                    begin
                        oam_sel = 1'b1;
                    end
                    default:
                    begin
                        rd = 8'd0;
                    end
                endcase
            end
            FN_WRITE:
            begin
                unique case (reg_select)
                    REG_DATA:
                    begin
                        we     = 1'b1;
                        wa     = v_reg[13:0];
                        wdat   = write_data;
                        v_next = v_step;
                    end
                    REG_CTRL:
                    begin
                        control_next  = write_data;
                        t_next[11:10] = write_data[1:0];
                    end
                    REG_MASK:
                    begin
                        mask_next = write_data;
                    end
                    REG_OAM_ADDR:
                    begin
                        oam_index_next = write_data;
                    end
                    REG_OAM_DATA:
                    begin
                        oam_wr         = 1'b1;
                        oam_index_next = oam_index_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!toggle_reg)
                        begin
                            fine_x_next = write_data[2:0];
                            t_next[4:0] = write_data[7:3];
                            toggle_next = 1'b1;
                        end
                        else
                        begin
                            t_next[14:12] = write_data[2:0];
                            t_next[9:5]   = write_data[7:3];
                            toggle_next   = 1'b0;
                        end
                    end
                    REG_ADDR:
                    begin
                        if (!toggle_reg)
                        begin
                            t_next[14]   = 1'b0;
                            t_next[13:8] = write_data[5:0];
                            toggle_next  = 1'b1;
                        end
                        else
                        begin
                            t_next[7:0] = write_data;
                            v_next      = {t_reg[14:8], write_data};
                            toggle_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        rd = 8'd0;
                    end
                endcase
            end
            FN_PEEK:
            begin
                unique case (reg_select)
                    REG_CTRL:     rd = control_reg;
                    REG_MASK:     rd = mask_reg;
                    REG_STATUS:   rd = status_reg;
                    REG_OAM_DATA: oam_sel = 1'b1;
                    default:      rd = 8'd0;
                endcase
            end
            FN_INC_X:
            begin
                if (render_on)
                begin
                    v_next = scroll_inc_x(v_reg);
                end
            end
            FN_INC_Y:
            begin
                if (render_on)
                begin
                    v_next = scroll_inc_y(v_reg);
                end
            end
            FN_XFER_X:
            begin
                if (render_on)
                begin
                    v_next[10]  = t_reg[10];
                    v_next[4:0] = t_reg[4:0];
                end
            end
            FN_XFER_Y:
            begin
                if (render_on)
                begin
                    v_next[14:11] = t_reg[14:11];
                    v_next[9:5]   = t_reg[9:5];
                end
            end
            FN_VBL_START:
            begin
                status_next[7] = 1'b1;
                nmi            = control_reg[7];
            end
            FN_VBL_END:
            begin
                status_next[7:5] = 3'b000;
            end
            default:
            begin
                rd = 8'd0;
            end
        endcase
    end

    ppurs_oam_mem #(
        .DEPTH (OAM_BYTES)
    ) u_oam (
        .clk     (clk),
        .wr_en   (in_accept & oam_wr),
        .wr_addr (oam_index_reg[OAM_AW-1:0]),
        .wr_data (write_data),
        .rd_en   (in_accept & oam_sel),
        .rd_addr (oam_index_reg[OAM_AW-1:0]),
        .rd_data (oam_q)
    );

    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= 8'd0;
            mask_reg      <= 8'd0;
            status_reg    <= 8'd0;
            oam_index_reg <= 8'd0;
            toggle_reg    <= 1'b0;
            rbuf_reg      <= 8'd0;
            v_reg         <= 15'd0;
            t_reg         <= 15'd0;
            fine_x_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                control_reg   <= control_next;
                mask_reg      <= mask_next;
                status_reg    <= status_next;
                oam_index_reg <= oam_index_next;
                toggle_reg    <= toggle_next;
                rbuf_reg      <= rbuf_next;
                v_reg         <= v_next;
                t_reg         <= t_next;
                fine_x_reg    <= fine_x_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_reg      <= rd;
            oam_sel_reg <= oam_sel;
            we_reg      <= we;
            wa_reg      <= wa;
            wdat_reg    <= wdat;
            v_now_reg   <= v_next;
            fx_now_reg  <= fine_x_next;
            nmi_reg     <= nmi;
        end
    end

    assign out_valid          = out_valid_reg;
    assign read_data          = oam_sel_reg ? oam_q : rd_reg;
    assign vram_write_enable  = we_reg;
    assign vram_write_address = wa_reg;
    assign vram_write_data    = wdat_reg;
    assign vram_address_now   = v_now_reg;
    assign fine_x_now         = fx_now_reg;
    assign nmi_request        = nmi_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_status_read_clears_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && fn == FN_READ && reg_select == REG_STATUS) |=> !toggle_reg)
        else $error("status read did not clear write toggle");

    a_vblank_sets_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && fn == FN_VBL_START) |=> status_reg[7])
        else $error("vblank start did not set status");

    a_oam_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && fn == FN_WRITE && reg_select == REG_OAM_DATA)
        |=> oam_index_reg == 8'($past(oam_index_reg) + 8'd1))
        else $error("OAM data write did not advance index");

endmodule

@@ rtl/ppurs_oam_mem.sv @@
module ppurs_oam_mem #(
    parameter int DEPTH = ppurs_pkg::OAM_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] oam_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            oam_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= oam_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
